@@ rtl/quicph_pkg.sv @@
// ----------------------------------------------------------------------------
// quicph_pkg
// Types and constants shared by the QUIC v1 packet header parser.
// ----------------------------------------------------------------------------
package quicph_pkg;

  localparam int unsigned MAX_DATAGRAM_BYTES = 65535;
  localparam int unsigned MAX_CID_BYTES      = 20;

  localparam logic [4:0]  SHORT_DCID_RESET = 5'd8;
  localparam logic [15:0] POS_MAX          = 16'(MAX_DATAGRAM_BYTES);
  localparam logic [7:0]  CID_MAX          = 8'(MAX_CID_BYTES);
  localparam logic [4:0]  CID_MAX_5        = 5'(MAX_CID_BYTES);

  // report status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_MALF  = 2'd2;

  // long header packet types
  localparam logic [1:0] LT_INITIAL = 2'd0;
  localparam logic [1:0] LT_RETRY   = 2'd3;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_VERSION,
    PH_DCID_LEN,
    PH_DCID,
    PH_SCID_LEN,
    PH_SCID,
    PH_TOKLEN,
    PH_TOKEN,
    PH_LENGTH,
    PH_DONE,
    PH_SHORT,
    PH_ERR
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_datagram;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_long;
    logic [1:0]  long_type;
    logic [7:0]  first_byte;
    logic [31:0] version;
    logic [4:0]  dcid_length;
    logic [4:0]  scid_length;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [15:0] pn_offset;
    logic [15:0] pn_payload_length;
    logic [15:0] packet_length;
  } report_t;

endpackage

@@ rtl/quic_packet_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// quic_packet_header_parser_unit
// Byte-serial QUIC v1 header parser: one datagram byte per transfer, one
// header report per datagram.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  item    | in  | item_valid/stall   | quicph_pkg::item_t (byte, last, empty)
//  report  | out | report_valid/stall | quicph_pkg::report_t (one per datagram)
//  cfg     | in  | cfg_valid/ready    | cfg_data = short_dcid_length
//
// One byte per cycle while item_stall is low. A byte updates the phase
// machine in the cycle it is taken; a datagram's last byte (or an empty
// datagram marker) loads its report into the output register or skid entry.
// rst (synchronous) rearms the parser at the first-byte phase and sets the
// short-header DCID length to 8.
// The report side has an output register plus one skid entry, so a stalled
// report only holds off item transfers once both are full.
module quic_packet_header_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  quicph_pkg::item_t   item,
  output logic                report_valid,
  input  logic                report_stall,
  output quicph_pkg::report_t report,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  // configuration
  logic [4:0] short_dcid_length;

  // per-datagram parse state
  quicph_pkg::phase_t phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  hdr_first, hdr_first_next;
  logic [31:0] version_shift, version_shift_next;
  logic [4:0]  dcid_len, dcid_len_next;
  logic [4:0]  scid_len, scid_len_next;
  // countdown saturates: anything above 65535 can never expire in one datagram
  logic [16:0] countdown, countdown_next;
  // varint: low 16 bits plus a flag for any higher bit set
  logic [15:0] vint_val, vint_val_next;
  logic        vint_big, vint_big_next;
  logic [2:0]  vint_left, vint_left_next;
  logic [15:0] token_start, token_start_next;
  logic [15:0] token_len, token_len_next;
  logic [15:0] number_offset, number_offset_next;
  logic [15:0] length_val, length_val_next;
  logic        length_big, length_big_next;

  // output register and skid entry
  logic                report_full;
  quicph_pkg::report_t skid;
  logic                skid_full;

  logic                item_xfer;
  logic                take;
  logic                finish;
  logic                report_xfer;
  quicph_pkg::report_t res;

  // varint step on the current byte
  logic [15:0] v_val;
  logic        v_big;
  logic [2:0]  v_left;
  logic        v_done;
  logic [15:0] next_pos;
  logic [15:0] size;

  assign cfg_ready    = 1'b1;
  assign item_stall   = skid_full;
  assign report_valid = report_full;
  assign item_xfer    = item_valid && !item_stall;
  assign report_xfer  = report_full && !report_stall;
  assign finish       = item_xfer && (item.empty_datagram || item.last_byte);
  // bytes beyond the maximum datagram size are dropped
  assign take         = item_xfer && !item.empty_datagram && (pos != quicph_pkg::POS_MAX);
  assign next_pos     = pos + 16'd1;

  always_comb begin
    if (vint_left == 3'd0) begin
      v_val = {10'd0, item.data_byte[5:0]};
      v_big = 1'b0;
      case (item.data_byte[7:6])
        2'd0:    v_left = 3'd0;
        2'd1:    v_left = 3'd1;
        2'd2:    v_left = 3'd3;
        default: v_left = 3'd7;
      endcase
    end else begin
      v_val  = {vint_val[7:0], item.data_byte};
      v_big  = vint_big || (vint_val[15:8] != 8'd0);
      v_left = vint_left - 3'd1;
    end
    v_done = (v_left == 3'd0);
  end

  // phase machine: next state for one byte
  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    hdr_first_next     = hdr_first;
    version_shift_next = version_shift;
    dcid_len_next      = dcid_len;
    scid_len_next      = scid_len;
    countdown_next     = countdown;
    vint_val_next      = vint_val;
    vint_big_next      = vint_big;
    vint_left_next     = vint_left;
    token_start_next   = token_start;
    token_len_next     = token_len;
    number_offset_next = number_offset;
    length_val_next    = length_val;
    length_big_next    = length_big;

    if (take) begin
      pos_next = next_pos;
      case (phase)
        quicph_pkg::PH_FIRST: begin
          hdr_first_next = item.data_byte;
          if (item.data_byte[7]) begin
            phase_next     = quicph_pkg::PH_VERSION;
            countdown_next = 17'd4;
          end else if (!item.data_byte[6] || short_dcid_length > quicph_pkg::CID_MAX_5) begin
            phase_next = quicph_pkg::PH_ERR;
          end else begin
            phase_next = quicph_pkg::PH_SHORT;
          end
        end
        quicph_pkg::PH_VERSION: begin
          version_shift_next = {version_shift[23:0], item.data_byte};
          countdown_next     = countdown - 17'd1;
          if (countdown_next == 17'd0) begin
            if (version_shift_next != 32'd1 || !hdr_first[6] ||
                hdr_first[5:4] == quicph_pkg::LT_RETRY) begin
              phase_next = quicph_pkg::PH_ERR;
            end else begin
              phase_next = quicph_pkg::PH_DCID_LEN;
            end
          end
        end
        quicph_pkg::PH_DCID_LEN, quicph_pkg::PH_SCID_LEN: begin
          if (item.data_byte > quicph_pkg::CID_MAX) begin
            phase_next = quicph_pkg::PH_ERR;
          end else begin
            countdown_next = {9'd0, item.data_byte};
            if (phase == quicph_pkg::PH_DCID_LEN) begin
              dcid_len_next = item.data_byte[4:0];
              phase_next    = (item.data_byte == 8'd0) ? quicph_pkg::PH_SCID_LEN
                                                       : quicph_pkg::PH_DCID;
            end else begin
              scid_len_next = item.data_byte[4:0];
              if (item.data_byte != 8'd0) begin
                phase_next = quicph_pkg::PH_SCID;
              end else if (hdr_first[5:4] == quicph_pkg::LT_INITIAL) begin
                phase_next = quicph_pkg::PH_TOKLEN;
              end else begin
                phase_next = quicph_pkg::PH_LENGTH;
              end
            end
          end
        end
        quicph_pkg::PH_DCID: begin
          countdown_next = countdown - 17'd1;
          if (countdown_next == 17'd0) begin
            phase_next = quicph_pkg::PH_SCID_LEN;
          end
        end
        quicph_pkg::PH_SCID: begin
          countdown_next = countdown - 17'd1;
          if (countdown_next == 17'd0) begin
            phase_next = (hdr_first[5:4] == quicph_pkg::LT_INITIAL) ? quicph_pkg::PH_TOKLEN
                                                                    : quicph_pkg::PH_LENGTH;
          end
        end
        quicph_pkg::PH_TOKLEN: begin
          vint_val_next  = v_val;
          vint_big_next  = v_big;
          vint_left_next = v_left;
          if (v_done) begin
            token_start_next = next_pos;
            token_len_next   = v_big ? 16'hFFFF : v_val;
            countdown_next   = v_big ? 17'h1FFFF : {1'b0, v_val};
            phase_next       = (!v_big && v_val == 16'd0) ? quicph_pkg::PH_LENGTH
                                                          : quicph_pkg::PH_TOKEN;
          end
        end
        quicph_pkg::PH_TOKEN: begin
          countdown_next = countdown - 17'd1;
          if (countdown_next == 17'd0) begin
            phase_next = quicph_pkg::PH_LENGTH;
          end
        end
        quicph_pkg::PH_LENGTH: begin
          vint_val_next  = v_val;
          vint_big_next  = v_big;
          vint_left_next = v_left;
          if (v_done) begin
            if (!v_big && v_val == 16'd0) begin
              phase_next = quicph_pkg::PH_ERR;
            end else begin
              length_val_next    = v_val;
              length_big_next    = v_big;
              number_offset_next = next_pos;
              phase_next         = quicph_pkg::PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // header report, built from the state after this byte
  always_comb begin
    size                  = pos_next;
    res                   = '0;
    res.status            = quicph_pkg::ST_TRUNC;
    res.is_long           = hdr_first_next[7];
    res.long_type         = hdr_first_next[7] ? hdr_first_next[5:4] : 2'd0;
    res.first_byte        = hdr_first_next;
    case (phase_next)
      quicph_pkg::PH_ERR: begin
        res.status = quicph_pkg::ST_MALF;
      end
      quicph_pkg::PH_SHORT: begin
        if ((size - 16'd1) >= {11'd0, short_dcid_length}) begin
          res.status            = quicph_pkg::ST_OK;
          res.dcid_length       = short_dcid_length;
          res.pn_offset         = {11'd0, short_dcid_length} + 16'd1;
          res.pn_payload_length = size - {11'd0, short_dcid_length} - 16'd1;
          res.packet_length     = size;
        end
      end
      quicph_pkg::PH_DONE: begin
        if (!length_big_next && length_val_next <= (size - number_offset_next)) begin
          res.status            = quicph_pkg::ST_OK;
          res.version           = version_shift_next;
          res.dcid_length       = dcid_len_next;
          res.scid_length       = scid_len_next;
          res.token_offset      = token_start_next;
          res.token_length      = token_len_next;
          res.pn_offset         = number_offset_next;
          res.pn_payload_length = length_val_next;
          res.packet_length     = number_offset_next + length_val_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_dcid_length <= quicph_pkg::SHORT_DCID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      short_dcid_length <= cfg_data;
    end
  end

  // parse state; a finished datagram rearms everything
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      phase         <= quicph_pkg::PH_FIRST;
      pos           <= '0;
      hdr_first     <= '0;
      version_shift <= '0;
      dcid_len      <= '0;
      scid_len      <= '0;
      countdown     <= '0;
      vint_val      <= '0;
      vint_big      <= 1'b0;
      vint_left     <= '0;
      token_start   <= '0;
      token_len     <= '0;
      number_offset <= '0;
      length_val    <= '0;
      length_big    <= 1'b0;
    end else begin
      phase         <= phase_next;
      pos           <= pos_next;
      hdr_first     <= hdr_first_next;
      version_shift <= version_shift_next;
      dcid_len      <= dcid_len_next;
      scid_len      <= scid_len_next;
      countdown     <= countdown_next;
      vint_val      <= vint_val_next;
      vint_big      <= vint_big_next;
      vint_left     <= vint_left_next;
      token_start   <= token_start_next;
      token_len     <= token_len_next;
      number_offset <= number_offset_next;
      length_val    <= length_val_next;
      length_big    <= length_big_next;
    end
  end

  // output register + skid; item_stall is high only while the skid holds one
  always_ff @(posedge clk) begin
    if (rst) begin
      report_full <= 1'b0;
      skid_full   <= 1'b0;
    end else if (skid_full) begin
      if (report_xfer) begin
        skid_full <= 1'b0;
      end
    end else if (finish) begin
      if (report_full && !report_xfer) begin
        skid_full <= 1'b1;
      end else begin
        report_full <= 1'b1;
      end
    end else if (report_xfer) begin
      report_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (report_xfer) begin
        report <= skid;
      end
    end else if (finish) begin
      if (report_full && !report_xfer) begin
        skid <= res;
      end else begin
        report <= res;
      end
    end
  end

endmodule
